>>> rtl/iol_pkg.sv
// shared widths, codes and transaction types for the indexed ordered list
package iol_pkg;

	localparam int POS_W        = 5;
	localparam int VAL_W        = 32;
	localparam int COUNT_W      = 5;
	localparam int MODE_W       = 2;
	localparam int STAT_W       = 2;
	localparam int DEF_CAPACITY = 16;

	typedef enum logic [MODE_W-1:0] {
		MODE_INSERT = 2'd0,
		MODE_DELETE = 2'd1,
		MODE_READ   = 2'd2,
		MODE_SEARCH = 2'd3
	} mode_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_DONE  = 2'd0,
		STAT_RANGE = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	// update command broadcast to every cell
	typedef struct packed {
		logic             ins_en;
		logic             del_en;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} iol_cmd_t;

	// contents of one cell as seen by its neighbours
	typedef struct packed {
		logic             occ;
		logic [VAL_W-1:0] entry;
	} iol_slot_t;

	// read and search results rippling along the row
	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] rd;
	} iol_chain_t;

endpackage

>>> rtl/iol_cell.sv
// one list cell: entry storage, shift update and result ripple stage
module iol_cell import iol_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic       clk,
	input  logic       arst_n,
	input  iol_cmd_t   cmd,
	input  iol_slot_t  left_slot,
	input  iol_slot_t  right_slot,
	output iol_slot_t  slot,
	input  iol_chain_t chain_in,
	output iol_chain_t chain_out
);

	logic             occ_q;
	logic [VAL_W-1:0] entry_q;
	iol_slot_t        slot_d;
	iol_chain_t       chain_q;
	iol_chain_t       chain_d;
	logic             is_eq;
	logic             is_gt;

	assign is_eq = (IDX == int'(cmd.pos));
	assign is_gt = (IDX > int'(cmd.pos));

	assign slot.occ   = occ_q;
	assign slot.entry = entry_q;

	always_comb begin
		slot_d.occ   = occ_q;
		slot_d.entry = entry_q;
		if (cmd.ins_en) begin
			if (is_eq) begin
				slot_d.occ   = 1'b1;
				slot_d.entry = cmd.value;
			end else if (is_gt) begin
				slot_d = left_slot;
			end
		end else if (cmd.del_en && (is_eq || is_gt)) begin
			slot_d = right_slot;
		end
	end

	always_comb begin
		chain_d.rd    = (occ_q && is_eq) ? entry_q : chain_in.rd;
		chain_d.found = chain_in.found | (occ_q && (entry_q == cmd.value));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else begin
			occ_q <= slot_d.occ;
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= slot_d.entry;
		chain_q <= chain_d;
	end

	assign chain_out = chain_q;

endmodule

>>> rtl/iol_ctrl.sv
// request sequencer: length count, status, scan timing and output register
module iol_ctrl import iol_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output iol_cmd_t                cmd,
	input  iol_chain_t              chain_end,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] read_value,
	output logic                    found,
	output logic [STAT_W-1:0]       status,
	output logic [COUNT_W-1:0]      count
);

	localparam int CW    = $clog2(CAPACITY + 1);
	localparam int MW    = (CW > POS_W) ? CW : POS_W;
	localparam int CMP_W = (MW > COUNT_W) ? MW : COUNT_W;

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_BUSY = 2'b10
	} state_t;

	state_t             state_q;
	mode_t              mode_q;
	logic [POS_W-1:0]   pos_q;
	logic [VAL_W-1:0]   value_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_d;
	logic [CW-1:0]      scan_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   read_value_q;
	logic               found_q;
	stat_t              status_q;
	logic [COUNT_W-1:0] count_out_q;
	stat_t              stat;
	logic [CMP_W-1:0]   pos_ext;
	logic [CMP_W-1:0]   cnt_ext;
	logic [CMP_W-1:0]   cnt_next_ext;
	logic               accept;
	logic               scan_op;
	logic               scan_done;
	logic               out_free;
	logic               done;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		pos_ext = CMP_W'(pos_q);
		cnt_ext = CMP_W'(count_q);
		stat    = STAT_DONE;
		case (mode_q)
			MODE_INSERT: begin
				if (pos_ext > cnt_ext) begin
					stat = STAT_RANGE;
				end else if (cnt_ext == CMP_W'(CAPACITY)) begin
					stat = STAT_FULL;
				end
			end
			MODE_DELETE, MODE_READ: begin
				if (pos_ext >= cnt_ext) begin
					stat = STAT_RANGE;
				end
			end
			default: begin
				stat = STAT_DONE;
			end
		endcase
	end

	assign scan_op   = (mode_q == MODE_READ) || (mode_q == MODE_SEARCH);
	assign scan_done = (scan_q == CW'(CAPACITY));
	assign out_free  = !out_valid_q || !out_stall;
	assign done      = (state_q == S_BUSY) && (!scan_op || scan_done) && out_free;

	assign cmd.ins_en = done && (mode_q == MODE_INSERT) && (stat == STAT_DONE);
	assign cmd.del_en = done && (mode_q == MODE_DELETE) && (stat == STAT_DONE);
	assign cmd.pos    = pos_q;
	assign cmd.value  = value_q;

	always_comb begin
		count_d = count_q;
		if (cmd.ins_en) begin
			count_d = count_q + CW'(1);
		end else if (cmd.del_en) begin
			count_d = count_q - CW'(1);
		end
	end

	assign cnt_next_ext = CMP_W'(count_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				state_q <= S_BUSY;
				scan_q  <= '0;
			end else if (done) begin
				state_q <= S_IDLE;
			end else if ((state_q == S_BUSY) && scan_op && !scan_done) begin
				scan_q <= scan_q + CW'(1);
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= mode_t'(mode);
			pos_q   <= position;
			value_q <= value;
		end
		if (done) begin
			read_value_q <= ((mode_q == MODE_READ) && (stat == STAT_DONE)) ? chain_end.rd : '0;
			found_q      <= (mode_q == MODE_SEARCH) ? chain_end.found : 1'b0;
			status_q     <= stat;
			count_out_q  <= cnt_next_ext[COUNT_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign found      = found_q;
	assign status     = status_q;
	assign count      = count_out_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length beyond capacity");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_en |=> (count_q == $past(count_q) + CW'(1)))
		else $error("insert did not grow the list by one");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && (stat == STAT_FULL)) |-> ((mode_q == MODE_INSERT) && (count_q == CW'(CAPACITY))))
		else $error("full status without a full list");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> ((state_q == S_BUSY) && (scan_q == '0)))
		else $error("accepted transaction not started");

endmodule

>>> rtl/indexed_ordered_list_unit.sv
// top level of the indexed ordered list: sequencer and row of cells
//
// Requests arrive on the input channel (in_valid, in_stall, mode, position, value);
// a transaction is taken at a rising edge with in_valid high and in_stall low.
// Each request gives exactly one result on the output channel (out_valid,
// out_stall, read_value, found, status, count), taken when out_valid is high
// and out_stall low.
// Insert and delete shift every cell together, at the same edge that registers the
// result and returns the sequencer to idle, where the next request can be taken.
// Read and search ripple through the row of cells, one cell per cycle, and their
// result is registered once the scan counter has reached the end of the row.
// The block holds one request at a time; a new request is taken while an
// earlier result still waits in the output register.
// When the receiver stalls, the result is held and a finished request waits for
// the output register to free before it updates the list.
// Reset empties the list and clears the output valid flag; stored entries are only
// seen through the occupancy bits, which reset clears.
module indexed_ordered_list_unit import iol_pkg::*; #(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VAL_W-1:0] read_value,
	output logic                    found,
	output logic [STAT_W-1:0]       status,
	output logic [COUNT_W-1:0]      count
);

	iol_cmd_t          cmd;
	iol_slot_t         slot    [CAPACITY];
	iol_slot_t         left_s  [CAPACITY];
	iol_slot_t         right_s [CAPACITY];
	iol_chain_t        chain   [CAPACITY+1];
	logic [CAPACITY-1:0] occ_vec;

	assign chain[0] = '0;

	iol_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.position   (position),
		.value      (value),
		.cmd        (cmd),
		.chain_end  (chain[CAPACITY]),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.found      (found),
		.status     (status),
		.count      (count)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign left_s[i] = '0;
		end else begin : g_mid_l
			assign left_s[i] = slot[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_s[i] = '0;
		end else begin : g_mid_r
			assign right_s[i] = slot[i+1];
		end

		iol_cell #(
			.IDX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.left_slot  (left_s[i]),
			.right_slot (right_s[i]),
			.slot       (slot[i]),
			.chain_in   (chain[i]),
			.chain_out  (chain[i+1])
		);

		assign occ_vec[i] = slot[i].occ;
	end

	// occupied cells always form an unbroken run from the head
	assert property (@(posedge clk) disable iff (!arst_n)
		(occ_vec & (occ_vec + CAPACITY'(1))) == '0)
		else $error("gap in occupied cells");

endmodule

>>> verif/indexed_ordered_list_unit_tb.sv
`timescale 1ns / 1ps
// testbench for the indexed ordered list unit: queued requests, random idling, list scoreboard
module indexed_ordered_list_unit_tb import iol_pkg::*; ();

	localparam int LIST_DEPTH = DEF_CAPACITY;
	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 8;

	typedef struct {
		mode_t                   op;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		bit                      hold;
	} request_t;

	typedef struct {
		logic signed [VAL_W-1:0] rd;
		logic                    found;
		stat_t                   st;
		logic [COUNT_W-1:0]      cnt;
	} outcome_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b1;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [MODE_W-1:0]       mode = MODE_INSERT;
	logic [POS_W-1:0]        position = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [VAL_W-1:0] read_value;
	logic                    found;
	logic [STAT_W-1:0]       status;
	logic [COUNT_W-1:0]      count;

	// list as the block should hold it
	logic signed [VAL_W-1:0] shadow_list [LIST_DEPTH] = '{default: '0};
	int shadow_len = 0;

	request_t request_q [$];
	outcome_t pending_outcomes [$];
	int n_planned = 0;
	int plan_len = 0;
	int n_sent = 0;
	int n_got = 0;
	int sent_total = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int n_ins = 0, n_del = 0, n_rd = 0, n_srch = 0;
	int n_range = 0, n_full = 0, n_hit = 0, peak_len = 0;

	logic signed [VAL_W-1:0] val_pool [8] = '{
		32'sd0, -32'sd1, 32'sd1, 32'sh7fffffff, 32'sh80000000, 32'sd42, -32'sd42, 32'sd1000
	};

	indexed_ordered_list_unit #(.CAPACITY(LIST_DEPTH)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.position(position),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.found(found),
		.status(status),
		.count(count)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic outcome_t list_apply(request_t rq);
		outcome_t r;
		int p;
		r.rd = '0;
		r.found = 1'b0;
		r.st = STAT_DONE;
		p = rq.pos;
		case (rq.op)
			MODE_INSERT: begin
				n_ins++;
				if (p > shadow_len) begin
					r.st = STAT_RANGE;
				end else if (shadow_len >= LIST_DEPTH) begin
					r.st = STAT_FULL;
				end else begin
					for (int i = shadow_len; i > p; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[p] = rq.val;
					shadow_len++;
				end
			end
			MODE_DELETE: begin
				n_del++;
				if (p >= shadow_len) begin
					r.st = STAT_RANGE;
				end else begin
					for (int i = p; i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_list[shadow_len-1] = '0;
					shadow_len--;
				end
			end
			MODE_READ: begin
				n_rd++;
				if (p >= shadow_len)
					r.st = STAT_RANGE;
				else
					r.rd = shadow_list[p];
			end
			default: begin
				n_srch++;
				for (int i = 0; i < shadow_len; i++)
					if (shadow_list[i] == rq.val)
						r.found = 1'b1;
				if (r.found)
					n_hit++;
			end
		endcase
		if (r.st == STAT_RANGE)
			n_range++;
		if (r.st == STAT_FULL)
			n_full++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
		r.cnt = COUNT_W'(shadow_len);
		return r;
	endfunction

	function automatic int idle_len(bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// queue one request and track the length it will leave behind
	function automatic void plan(mode_t op, int pos, logic signed [VAL_W-1:0] val, bit hold);
		request_t rq;
		rq.op = op;
		rq.pos = POS_W'(pos);
		rq.val = val;
		rq.hold = hold;
		request_q.push_back(rq);
		n_planned++;
		if (op == MODE_INSERT && pos <= plan_len && plan_len < LIST_DEPTH)
			plan_len++;
		else if (op == MODE_DELETE && pos < plan_len)
			plan_len--;
	endfunction

	// driver
	request_t cur_req;
	bit driving = 1'b0;
	bit calm_tx = 1'b0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (driving && !in_stall) begin
				pending_outcomes.push_back(list_apply(cur_req));
				sent_total++;
				n_sent <= sent_total;
				driving = 1'b0;
				if ($urandom_range(0, 49) == 0)
					calm_tx = !calm_tx;
				gap_left = idle_len(calm_tx);
			end
			if (!driving) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (request_q.size() != 0 &&
						!(request_q[0].hold && n_got != sent_total)) begin
					cur_req = request_q.pop_front();
					mode <= cur_req.op;
					position <= cur_req.pos;
					value <= cur_req.val;
					driving = 1'b1;
				end
			end
			in_valid <= driving;
		end
	end

	// monitor
	outcome_t want;
	bit calm_rx = 1'b0;
	int stall_left = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (n_got >= n_sent) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					want = pending_outcomes.pop_front();
					n_got <= n_got + 1;
					if (read_value !== want.rd) begin
						$error("read_value: expected %0d, got %0d", want.rd, read_value);
						fail_count++;
					end
					if (found !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, found);
						fail_count++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (count !== want.cnt) begin
						$error("count: expected %0d, got %0d", want.cnt, count);
						fail_count++;
					end
				end
				if ($urandom_range(0, 49) == 0)
					calm_rx = !calm_rx;
			end
			if (stall_left == 0 && !calm_rx && $urandom_range(0, 3) == 0)
				stall_left = idle_len(1'b0);
			out_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int r;
		int k;
		int pos;
		bit filling;
		mode_t op;
		logic signed [VAL_W-1:0] v;

		// falling edge so the asynchronous reset takes effect
		arst_n <= 1'b0;

		// empty list corner cases
		plan(MODE_DELETE, 0, 32'sd0, 1'b0);
		plan(MODE_READ, 0, 32'sd0, 1'b0);
		plan(MODE_SEARCH, 0, 32'sd0, 1'b0);
		plan(MODE_INSERT, 16, 32'sd5, 1'b0);
		plan(MODE_INSERT, 0, 32'sh7fffffff, 1'b0);
		plan(MODE_INSERT, 0, 32'sh80000000, 1'b0);
		plan(MODE_INSERT, 2, -32'sd1, 1'b0);
		plan(MODE_INSERT, 1, 32'sd0, 1'b0);
		while (plan_len < LIST_DEPTH)
			plan(MODE_INSERT, $urandom_range(0, plan_len), $urandom, 1'b0);
		// full list, end of list, freed last slot
		plan(MODE_INSERT, 16, 32'sd7, 1'b0);
		plan(MODE_READ, 15, 32'sd0, 1'b0);
		plan(MODE_READ, 16, 32'sd0, 1'b0);
		plan(MODE_SEARCH, 0, 32'sh80000000, 1'b0);
		plan(MODE_DELETE, 15, 32'sd0, 1'b0);

		filling = 1'b0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				filling = !filling;
			r = $urandom_range(0, 99);
			if (r < (filling ? 50 : 15))
				op = MODE_INSERT;
			else if (r < 65)
				op = MODE_DELETE;
			else if (r < 85)
				op = MODE_READ;
			else
				op = MODE_SEARCH;
			k = $urandom_range(0, 9);
			if (k == 0)
				pos = $urandom_range(0, 16);
			else if (k == 1)
				pos = (op == MODE_INSERT) ?
					((plan_len < LIST_DEPTH) ? $urandom_range(plan_len + 1, 16) : 16) :
					$urandom_range(plan_len, 16);
			else if (op == MODE_INSERT)
				pos = $urandom_range(0, plan_len);
			else
				pos = (plan_len == 0) ? 0 : $urandom_range(0, plan_len - 1);
			v = ($urandom_range(0, 2) == 0) ? val_pool[$urandom_range(0, 7)] : $urandom;
			plan(op, pos, v, (n % 250 == 0));
		end

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		while (n_got != n_planned)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests: %0d insert, %0d delete, %0d read, %0d search", n_planned,
			n_ins, n_del, n_rd, n_srch);
		$display("%0d out of range, %0d refused as full, %0d search hits, longest list %0d",
			n_range, n_full, n_hit, peak_len);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
